// ===== sv/bos_pkg.sv =====
// ----------------------------------------------------------------------------
// bos_pkg
// Shared types and constants of the bounded operand stack: request and
// status codes, sequencer states and the default store depth.
// ----------------------------------------------------------------------------
package bos_pkg;

	localparam int unsigned WORD_W        = 32;
	localparam int unsigned DEPTH_DEFAULT = 8;
	localparam int unsigned REQ_W         = 3;
	localparam int unsigned INDEX_W       = 3;
	localparam int unsigned STATUS_W      = 2;
	localparam int unsigned COUNT_W       = 4;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [REQ_W-1:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_SWAP  = 3'd2,
		OP_DUP   = 3'd3,
		OP_CLEAR = 3'd4,
		OP_PEEK  = 3'd5,
		OP_POP2  = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_EXEC   = 2'd1,
		S_SECOND = 2'd2,
		S_SWAPW  = 2'd3
	} state_t;

endpackage

// ===== sv/bos_req_if.sv =====
// ----------------------------------------------------------------------------
// bos_req_if
// Request channel of the operand stack: valid/ready plus one request.
// ----------------------------------------------------------------------------
interface bos_req_if;

	logic                          valid;
	logic                          ready;
	logic [bos_pkg::REQ_W-1:0]     req_type;
	bos_pkg::word_t                push_value;
	logic [bos_pkg::INDEX_W-1:0]   peek_index;

	modport source (output valid, output req_type, output push_value, output peek_index,
		input ready);
	modport sink (input valid, input req_type, input push_value, input peek_index,
		output ready);

endinterface

// ===== sv/bos_res_if.sv =====
// ----------------------------------------------------------------------------
// bos_res_if
// Result channel of the operand stack: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface bos_res_if;

	logic                          valid;
	logic                          ready;
	logic [bos_pkg::STATUS_W-1:0]  status;
	bos_pkg::word_t                first_word;
	bos_pkg::word_t                second_word;
	logic [bos_pkg::COUNT_W-1:0]   entry_count;

	modport source (output valid, output status, output first_word, output second_word,
		output entry_count, input ready);
	modport sink (input valid, input status, input first_word, input second_word,
		input entry_count, output ready);

endinterface

// ===== sv/bos_ram.sv =====
// ----------------------------------------------------------------------------
// bos_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bos_ram #(
	parameter int unsigned WIDTH = bos_pkg::WORD_W,
	parameter int unsigned DEPTH = bos_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/bounded_operand_stack.sv =====
// ----------------------------------------------------------------------------
// bounded_operand_stack
// LIFO of signed words for an RPN calculator, held in one RAM.
// ----------------------------------------------------------------------------
// One request at a time is taken and each gives one result. The entries live
// in a single RAM with one write port and one registered read port, so the
// sequencer issues its reads and writes one after another: push, pop,
// duplicate, clear, peek and every failed request load their result in the
// execute state that follows the transaction (the first read is issued with the
// transaction, the update follows), pop two first reads the second entry and
// then loads, and swap reads the second entry, then makes two write-backs. The
// next request is taken the cycle after the result is loaded into the output
// register; a result that has not been taken yet stalls only the final step of
// the following request, the one that loads its result. The RAM is not cleared
// after reset: only data from positions below the entry count is ever used.
module bounded_operand_stack #(
	parameter int unsigned DEPTH = bos_pkg::DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	bos_req_if.sink   req,
	bos_res_if.source res
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > bos_pkg::INDEX_W) ? CW : bos_pkg::INDEX_W;

	bos_pkg::state_t  state_q, state_d;
	bos_pkg::op_t     op_q;
	bos_pkg::word_t   val_q;
	bos_pkg::word_t   a_q;
	logic [bos_pkg::INDEX_W-1:0] idx_q;
	logic [CW-1:0]    cnt_q, cnt_d;

	logic             res_valid_q;
	bos_pkg::status_t res_status_q, res_status_d;
	bos_pkg::word_t   res_first_q, res_first_d;
	bos_pkg::word_t   res_second_q, res_second_d;
	logic [bos_pkg::COUNT_W-1:0] res_count_q;

	logic                       mem_we, mem_re;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	logic [bos_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

	logic          accept, out_free, load_res, save_a;
	logic          full, empty, lt2, peek_miss, needs_second;
	logic [AW-1:0] top_addr, below_addr, push_addr;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == bos_pkg::S_IDLE);
	assign out_free = !res_valid_q || res.ready;

	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign lt2       = (cnt_q < CW'(2));
	assign peek_miss = (XW'(idx_q) >= XW'(cnt_q));
	assign needs_second = (op_q inside {bos_pkg::OP_SWAP, bos_pkg::OP_POP2}) && !lt2;

	// count never exceeds DEPTH; these wrap at the ends of the range, where they go unused
	assign top_addr   = AW'(cnt_q - CW'(1));
	assign below_addr = AW'(cnt_q - CW'(2));
	assign push_addr  = AW'(cnt_q);

	bos_ram #(
		.WIDTH (bos_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bos_pkg::S_IDLE: begin
				if (accept) begin
					state_d = bos_pkg::S_EXEC;
				end
			end
			bos_pkg::S_EXEC: begin
				if (needs_second) begin
					state_d = bos_pkg::S_SECOND;
				end else if (out_free) begin
					state_d = bos_pkg::S_IDLE;
				end
			end
			bos_pkg::S_SECOND: begin
				if (op_q == bos_pkg::OP_SWAP) begin
					state_d = bos_pkg::S_SWAPW;
				end else if (out_free) begin
					state_d = bos_pkg::S_IDLE;
				end
			end
			bos_pkg::S_SWAPW: begin
				if (out_free) begin
					state_d = bos_pkg::S_IDLE;
				end
			end
			default: state_d = bos_pkg::S_IDLE;
		endcase
	end

	// RAM accesses, count update and result
	always_comb begin
		mem_re       = 1'b0;
		mem_raddr    = top_addr;
		mem_we       = 1'b0;
		mem_waddr    = push_addr;
		mem_wdata    = val_q;
		cnt_d        = cnt_q;
		load_res     = 1'b0;
		save_a       = 1'b0;
		res_status_d = bos_pkg::ST_OK;
		res_first_d  = '0;
		res_second_d = '0;
		case (state_q)
			bos_pkg::S_IDLE: begin
				mem_re = accept;
				if (bos_pkg::op_t'(req.req_type) == bos_pkg::OP_PEEK) begin
					mem_raddr = AW'(req.peek_index);
				end
			end
			bos_pkg::S_EXEC: begin
				if (needs_second) begin
					mem_re    = 1'b1;
					mem_raddr = below_addr;
					save_a    = 1'b1;
				end else if (out_free) begin
					load_res = 1'b1;
					case (op_q)
						bos_pkg::OP_PUSH: begin
							if (full) begin
								res_status_d = bos_pkg::ST_OVERFLOW;
							end else begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + CW'(1);
							end
						end
						bos_pkg::OP_POP: begin
							if (empty) begin
								res_status_d = bos_pkg::ST_UNDERFLOW;
							end else begin
								res_first_d = mem_rdata;
								cnt_d       = cnt_q - CW'(1);
							end
						end
						bos_pkg::OP_DUP: begin
							// underflow takes priority over overflow
							if (empty) begin
								res_status_d = bos_pkg::ST_UNDERFLOW;
							end else if (full) begin
								res_status_d = bos_pkg::ST_OVERFLOW;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = mem_rdata;
								cnt_d     = cnt_q + CW'(1);
							end
						end
						bos_pkg::OP_CLEAR: cnt_d = '0;
						bos_pkg::OP_PEEK: begin
							if (peek_miss) begin
								res_status_d = bos_pkg::ST_EMPTY;
							end else begin
								res_first_d = mem_rdata;
							end
						end
						// swap and pop two only get here with fewer than two entries
						bos_pkg::OP_SWAP, bos_pkg::OP_POP2: res_status_d = bos_pkg::ST_UNDERFLOW;
						default: ;
					endcase
				end
			end
			bos_pkg::S_SECOND: begin
				if (op_q == bos_pkg::OP_SWAP) begin
					mem_we    = 1'b1;
					mem_waddr = top_addr;
					mem_wdata = mem_rdata;
				end else if (out_free) begin
					load_res     = 1'b1;
					res_first_d  = a_q;
					res_second_d = mem_rdata;
					cnt_d        = cnt_q - CW'(2);
				end
			end
			bos_pkg::S_SWAPW: begin
				if (out_free) begin
					mem_we    = 1'b1;
					mem_waddr = below_addr;
					mem_wdata = a_q;
					load_res  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bos_pkg::S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= bos_pkg::op_t'(req.req_type);
			val_q <= req.push_value;
			idx_q <= req.peek_index;
		end
		if (save_a) begin
			a_q <= mem_rdata;
		end
		if (load_res) begin
			res_status_q <= res_status_d;
			res_first_q  <= res_first_d;
			res_second_q <= res_second_d;
			res_count_q  <= bos_pkg::COUNT_W'(cnt_d);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = res_status_q;
	assign res.first_word  = res_first_q;
	assign res.second_word = res_second_q;
	assign res.entry_count = res_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> (!res_valid_q || res.ready))
		else $error("result loaded over a pending result");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bos_pkg::S_IDLE) |-> !mem_we)
		else $error("RAM written while idle");

	a_count_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(load_res))
		else $error("entry count changed without a result");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_status_q != bos_pkg::ST_OK)) |->
		((res_first_q == '0) && (res_second_q == '0)))
		else $error("error result carries data");

endmodule

// ===== dv/tb_bounded_operand_stack.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_operand_stack
// Self-checking bench for the operand stack. A bench-side stack works out the
// expected result of every request. Directed corner cases come first, then
// repeated fill/drain rounds and a random RPN-style mix. Requests go out in
// bursts with gaps, and the result side stalls in shifting patterns.
// ----------------------------------------------------------------------------
module tb_bounded_operand_stack;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STACK_DEPTH  = bos_pkg::DEPTH_DEFAULT;
	localparam int unsigned IDLE_LIMIT   = 500;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam logic [bos_pkg::REQ_W-1:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		bos_pkg::status_t             status;
		bos_pkg::word_t               first;
		bos_pkg::word_t               second;
		logic [bos_pkg::COUNT_W-1:0]  count;
	} stack_result_t;

	typedef enum int unsigned {
		RX_OPEN,
		RX_COIN,
		RX_PULSE,
		RX_RARE_STALL
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	bos_req_if req_ch ();
	bos_res_if res_ch ();

	bounded_operand_stack #(.DEPTH(STACK_DEPTH)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the stack
	bos_pkg::word_t stack_words [STACK_DEPTH];
	int unsigned    stack_fill;
	stack_result_t  pending_results [$];

	int unsigned error_count;
	int unsigned results_checked;
	int unsigned idle_cycles;
	int unsigned burst_left;
	int unsigned rx_phase;
	rx_mode_t    rx_mode;
	int unsigned op_seen [8];
	int unsigned status_seen [4];

	function automatic stack_result_t stack_apply(input logic [bos_pkg::REQ_W-1:0] op,
		input bos_pkg::word_t value, input logic [bos_pkg::INDEX_W-1:0] idx);
		stack_result_t  r;
		bos_pkg::word_t tmp;
		r.status = bos_pkg::ST_OK;
		r.first  = '0;
		r.second = '0;
		case (op)
		bos_pkg::OP_PUSH: begin
			if (stack_fill >= STACK_DEPTH) begin
				r.status = bos_pkg::ST_OVERFLOW;
			end else begin
				stack_words[stack_fill] = value;
				stack_fill++;
			end
		end
		bos_pkg::OP_POP: begin
			if (stack_fill == 0) begin
				r.status = bos_pkg::ST_UNDERFLOW;
			end else begin
				stack_fill--;
				r.first = stack_words[stack_fill];
			end
		end
		bos_pkg::OP_SWAP: begin
			if (stack_fill < 2) begin
				r.status = bos_pkg::ST_UNDERFLOW;
			end else begin
				tmp                         = stack_words[stack_fill - 1];
				stack_words[stack_fill - 1] = stack_words[stack_fill - 2];
				stack_words[stack_fill - 2] = tmp;
			end
		end
		bos_pkg::OP_DUP: begin
			// underflow wins over overflow
			if (stack_fill == 0) begin
				r.status = bos_pkg::ST_UNDERFLOW;
			end else if (stack_fill >= STACK_DEPTH) begin
				r.status = bos_pkg::ST_OVERFLOW;
			end else begin
				stack_words[stack_fill] = stack_words[stack_fill - 1];
				stack_fill++;
			end
		end
		bos_pkg::OP_CLEAR: stack_fill = 0;
		bos_pkg::OP_PEEK: begin
			if (idx >= stack_fill) r.status = bos_pkg::ST_EMPTY;
			else r.first = stack_words[idx];
		end
		bos_pkg::OP_POP2: begin
			// a failed pop two leaves the single entry in place
			if (stack_fill < 2) begin
				r.status = bos_pkg::ST_UNDERFLOW;
			end else begin
				r.first     = stack_words[stack_fill - 1];
				r.second    = stack_words[stack_fill - 2];
				stack_fill -= 2;
			end
		end
		default: ;
		endcase
		r.count = bos_pkg::COUNT_W'(stack_fill);
		return r;
	endfunction

	function automatic bos_pkg::word_t rand_word();
		case ($urandom_range(0, 7))
		0:       return bos_pkg::word_t'(32'h7fff_ffff);
		1:       return bos_pkg::word_t'(32'h8000_0000);
		2:       return bos_pkg::word_t'(32'hffff_ffff);
		3:       return '0;
		default: return bos_pkg::word_t'($urandom);
		endcase
	endfunction

	function automatic logic [bos_pkg::INDEX_W-1:0] rand_index();
		return bos_pkg::INDEX_W'($urandom_range(0, 7));
	endfunction

	task automatic send_request(input logic [bos_pkg::REQ_W-1:0] op,
		input bos_pkg::word_t value, input logic [bos_pkg::INDEX_W-1:0] idx);
		stack_result_t r;
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= op;
		req_ch.push_value <= value;
		req_ch.peek_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		r = stack_apply(op, value, idx);
		pending_results.push_back(r);
		op_seen[op]++;
		burst_left--;
	endtask

	// hold requests back until every outstanding result has been taken
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic compare_field(input string field,
		input logic [bos_pkg::WORD_W-1:0] want, input logic [bos_pkg::WORD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			error_count++;
		end
	endtask

	task automatic test_empty_store();
		send_request(bos_pkg::OP_POP, rand_word(), 3'd0);
		send_request(bos_pkg::OP_SWAP, rand_word(), 3'd0);
		send_request(bos_pkg::OP_DUP, rand_word(), 3'd0);
		send_request(bos_pkg::OP_POP2, rand_word(), 3'd0);
		send_request(bos_pkg::OP_PEEK, rand_word(), 3'd0);
		send_request(OP_UNUSED, rand_word(), 3'd7);
	endtask

	task automatic test_single_entry();
		send_request(bos_pkg::OP_PUSH, bos_pkg::word_t'(32'h7fff_ffff), 3'd0);
		send_request(bos_pkg::OP_POP2, '0, 3'd0);
		send_request(bos_pkg::OP_SWAP, '0, 3'd0);
		send_request(bos_pkg::OP_PEEK, '0, 3'd0);
		send_request(bos_pkg::OP_PEEK, '0, 3'd1);
		send_request(bos_pkg::OP_DUP, '0, 3'd0);
		send_request(bos_pkg::OP_POP2, '0, 3'd0);
	endtask

	task automatic test_full_store();
		send_request(bos_pkg::OP_PUSH, bos_pkg::word_t'(32'h8000_0000), 3'd0);
		send_request(bos_pkg::OP_PUSH, bos_pkg::word_t'(32'hffff_ffff), 3'd0);
		send_request(bos_pkg::OP_PUSH, '0, 3'd0);
		send_request(bos_pkg::OP_PUSH, bos_pkg::word_t'(32'h5555_5555), 3'd0);
		send_request(bos_pkg::OP_PUSH, bos_pkg::word_t'(32'haaaa_aaaa), 3'd0);
		send_request(bos_pkg::OP_PUSH, bos_pkg::word_t'(32'h7fff_ffff), 3'd0);
		send_request(bos_pkg::OP_DUP, '0, 3'd0);
		send_request(bos_pkg::OP_DUP, '0, 3'd0);
		send_request(bos_pkg::OP_PUSH, bos_pkg::word_t'(32'h1234_5678), 3'd0);
		send_request(bos_pkg::OP_DUP, '0, 3'd0);
		send_request(bos_pkg::OP_PEEK, '0, 3'd7);
		send_request(bos_pkg::OP_SWAP, '0, 3'd0);
		send_request(bos_pkg::OP_POP2, '0, 3'd0);
		send_request(bos_pkg::OP_CLEAR, '0, 3'd0);
	endtask

	task automatic test_fill_and_drain(input int unsigned rounds);
		logic [bos_pkg::REQ_W-1:0] short_ops [5] = '{bos_pkg::OP_POP, bos_pkg::OP_SWAP,
			bos_pkg::OP_POP2, bos_pkg::OP_DUP, bos_pkg::OP_PEEK};
		for (int unsigned n = 0; n < rounds; n++) begin
			while (stack_fill < STACK_DEPTH) begin
				if (stack_fill != 0 && $urandom_range(0, 3) == 0)
					send_request(bos_pkg::OP_DUP, rand_word(), rand_index());
				else
					send_request(bos_pkg::OP_PUSH, rand_word(), rand_index());
			end
			send_request($urandom_range(0, 1) ? bos_pkg::OP_PUSH : bos_pkg::OP_DUP,
				rand_word(), rand_index());
			send_request(bos_pkg::OP_PEEK, rand_word(), rand_index());
			send_request(bos_pkg::OP_SWAP, rand_word(), rand_index());
			while (stack_fill != 0)
				send_request((stack_fill >= 2 && $urandom_range(0, 1)) ? bos_pkg::OP_POP2
					: bos_pkg::OP_POP, rand_word(), rand_index());
			send_request(short_ops[$urandom_range(0, 4)], rand_word(), rand_index());
		end
	endtask

	task automatic test_random_mix(input int unsigned items);
		int unsigned                 pick;
		logic [bos_pkg::REQ_W-1:0]   op;
		logic [bos_pkg::INDEX_W-1:0] idx;
		for (int unsigned n = 0; n < items; n++) begin
			if (n == items / 2) wait_for_results();
			pick = $urandom_range(0, 99);
			// lean towards pushes on a shallow stack so the deep states get traffic
			if (stack_fill < 3 && pick < 50) op = bos_pkg::OP_PUSH;
			else if (pick < 30) op = bos_pkg::OP_PUSH;
			else if (pick < 42) op = bos_pkg::OP_POP;
			else if (pick < 52) op = bos_pkg::OP_SWAP;
			else if (pick < 64) op = bos_pkg::OP_DUP;
			else if (pick < 67) op = bos_pkg::OP_CLEAR;
			else if (pick < 80) op = bos_pkg::OP_PEEK;
			else if (pick < 97) op = bos_pkg::OP_POP2;
			else op = OP_UNUSED;
			if (stack_fill != 0 && $urandom_range(0, 1))
				idx = bos_pkg::INDEX_W'($urandom_range(0, stack_fill - 1));
			else
				idx = rand_index();
			send_request(op, rand_word(), idx);
		end
	endtask

	// result side: the stall pattern is redrawn whenever its phase counter runs out
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_mode  = rx_mode_t'($urandom_range(0, 3));
			rx_phase = $urandom_range(20, 80);
		end
		rx_phase--;
		case (rx_mode)
		RX_OPEN:  res_ch.ready <= 1'b1;
		RX_COIN:  res_ch.ready <= 1'($urandom_range(0, 1));
		RX_PULSE: res_ch.ready <= (rx_phase % 4 == 0);
		default:  res_ch.ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin : check_results
		stack_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display({"%0t: unexpected result: expected none, actual status %0d",
					" first %0h second %0h count %0d"},
					$time, res_ch.status, res_ch.first_word, res_ch.second_word,
					res_ch.entry_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("status", bos_pkg::WORD_W'(want.status), 
					bos_pkg::WORD_W'(res_ch.status));
				compare_field("first_word", want.first, res_ch.first_word);
				compare_field("second_word", want.second, res_ch.second_word);
				compare_field("entry_count", bos_pkg::WORD_W'(want.count),
					bos_pkg::WORD_W'(res_ch.entry_count));
				status_seen[want.status]++;
				results_checked++;
			end
		end
	end

	// a transaction on either side restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, IDLE_LIMIT, pending_results.size());
				$display("tb_bounded_operand_stack: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= bos_pkg::OP_PUSH;
		req_ch.push_value <= '0;
		req_ch.peek_index <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_single_entry();
		test_full_store();
		wait_for_results();
		test_fill_and_drain(10);
		test_random_mix(370);
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			error_count++;
		end
		$display({"requests: push %0d, pop %0d, swap %0d, dup %0d, clear %0d,",
			" peek %0d, pop two %0d, unused %0d"},
			op_seen[bos_pkg::OP_PUSH], op_seen[bos_pkg::OP_POP], op_seen[bos_pkg::OP_SWAP],
			op_seen[bos_pkg::OP_DUP], op_seen[bos_pkg::OP_CLEAR], op_seen[bos_pkg::OP_PEEK],
			op_seen[bos_pkg::OP_POP2], op_seen[OP_UNUSED]);
		$display("%0d results checked: %0d ok, %0d overflow, %0d underflow, %0d empty field",
			results_checked, status_seen[bos_pkg::ST_OK], status_seen[bos_pkg::ST_OVERFLOW],
			status_seen[bos_pkg::ST_UNDERFLOW], status_seen[bos_pkg::ST_EMPTY]);
		if (error_count == 0) begin
			$display("tb_bounded_operand_stack: clean");
		end else begin
			$display("tb_bounded_operand_stack: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/bos_pkg.sv
sv/bos_req_if.sv
sv/bos_res_if.sv
sv/bos_ram.sv
sv/bounded_operand_stack.sv
dv/tb_bounded_operand_stack.sv
